// ----- hdl/lpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LPM route table package
// Command codes, the token that walks the cell chain and the prefix mask.
// ----------------------------------------------------------------------------
package lpm_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam int ADDR_W = 32;
   localparam int LEN_W  = 6;
   localparam int PORT_W = 8;

   typedef struct packed {
      logic              vld;
      logic [1:0]        cmd;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      logic [PORT_W-1:0] port;
      logic [ADDR_W-1:0] hop;
      logic              done;
      logic              claimed;
      logic              found;
      logic [LEN_W-1:0]  best_len;
      logic [ADDR_W-1:0] best_hop;
      logic [PORT_W-1:0] best_port;
   } token_type;

   function automatic logic [ADDR_W-1:0] low_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] m;
      if (len >= LEN_W'(ADDR_W)) begin
         m = '1;
      end else begin
         m = (ADDR_W'(1) << len) - ADDR_W'(1);
      end
      return m;
   endfunction

endpackage

// ----- hdl/lpm_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LPM route table cell
// Holds one route slot and applies each passing command token to it.
// ----------------------------------------------------------------------------
module lpm_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  lpm_pkg::token_type tok_i,
   output lpm_pkg::token_type tok_o
);
   import lpm_pkg::*;

   logic              ent_vld_ff, ent_vld_in;
   logic [ADDR_W-1:0] ent_prefix_ff, ent_prefix_in;
   logic [LEN_W-1:0]  ent_len_ff, ent_len_in;
   logic [PORT_W-1:0] ent_port_ff, ent_port_in;
   logic [ADDR_W-1:0] ent_hop_ff, ent_hop_in;
   token_type         tok_ff, tok_in;
   logic              ent_hit;
   logic [ADDR_W-1:0] m;

   always_comb begin
      ent_vld_in    = ent_vld_ff;
      ent_prefix_in = ent_prefix_ff;
      ent_len_in    = ent_len_ff;
      ent_port_in   = ent_port_ff;
      ent_hop_in    = ent_hop_ff;
      tok_in        = tok_i;
      m             = low_mask(ent_len_ff);
      ent_hit = ent_vld_ff && (ent_prefix_ff == tok_i.addr) && (ent_len_ff == tok_i.len);
      if (tok_i.vld) begin
         unique case (tok_i.cmd)
            CMD_INSERT: begin
               if (ent_hit) begin
                  if (!tok_i.done) begin
                     ent_port_in = tok_i.port;
                     ent_hop_in  = tok_i.hop;
                     tok_in.done = 1'b1;
                  end else if (tok_i.claimed) begin
                     ent_vld_in = 1'b0;
                  end
               end else if (!ent_vld_ff && !tok_i.done) begin
                  ent_vld_in     = 1'b1;
                  ent_prefix_in  = tok_i.addr;
                  ent_len_in     = tok_i.len;
                  ent_port_in    = tok_i.port;
                  ent_hop_in     = tok_i.hop;
                  tok_in.done    = 1'b1;
                  tok_in.claimed = 1'b1;
               end
            end
            CMD_DELETE: begin
               if (ent_hit) begin
                  ent_vld_in = 1'b0;
               end
            end
            CMD_QUERY: begin
               if (ent_vld_ff && ((tok_i.addr & m) == ent_prefix_ff)
                   && (!tok_i.found || (ent_len_ff > tok_i.best_len))) begin
                  tok_in.found     = 1'b1;
                  tok_in.best_len  = ent_len_ff;
                  tok_in.best_hop  = ent_hop_ff;
                  tok_in.best_port = ent_port_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= 1'b0;
         tok_ff     <= '0;
      end else if (adv) begin
         ent_vld_ff <= ent_vld_in;
         tok_ff     <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ent_prefix_ff <= ent_prefix_in;
         ent_len_ff    <= ent_len_in;
         ent_port_ff   <= ent_port_in;
         ent_hop_ff    <= ent_hop_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

// ----- hdl/lpm_route_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LPM route table top level
// Each command passes through every cell of the chain and leaves the last as the response.
// Throughput: one command per cycle; each command walks one cell per cycle.
// The chain stalls as a whole while a response waits for transfer.
// Reset empties the table at once and drops every command in flight.
// ----------------------------------------------------------------------------
module lpm_route_table_top #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[1:0], address[33:2], prefix_len[39:34], port[47:40], next_hop[79:48]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // found[0], hop_out[32:1], port_out[40:33], status[41], zero[47:42]
   output logic [47:0] rsp_tdata
);
   import lpm_pkg::*;

   token_type         chain [0:TABLE_DEPTH];
   token_type         head;
   token_type         last;
   logic              adv;
   logic [LEN_W-1:0]  raw_len, len;
   logic [1:0]        cmd;
   logic [ADDR_W-1:0] addr;

   assign last       = chain[TABLE_DEPTH];
   assign adv        = !last.vld || rsp_tready;
   assign req_tready = adv;
   assign chain[0]   = head;

   always_comb begin
      cmd     = req_tdata[1:0];
      addr    = req_tdata[33:2];
      raw_len = req_tdata[39:34];
      len     = (raw_len > LEN_W'(ADDR_W)) ? LEN_W'(ADDR_W) : raw_len;
      head           = '0;
      head.vld       = req_tvalid;
      head.cmd       = cmd;
      head.addr      = (cmd == CMD_QUERY) ? addr : (addr & low_mask(len));
      head.len       = len;
      head.port      = req_tdata[47:40];
      head.hop       = req_tdata[79:48];
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      lpm_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .tok_i (chain[i]),
         .tok_o (chain[i+1])
      );
   end

   always_comb begin
      rsp_tvalid      = last.vld;
      rsp_tdata       = '0;
      if (last.cmd == CMD_QUERY && last.found) begin
         rsp_tdata[0]     = 1'b1;
         rsp_tdata[32:1]  = last.best_hop;
         rsp_tdata[40:33] = last.best_port;
      end
      rsp_tdata[41] = (last.cmd == CMD_INSERT) && !last.done;
   end

endmodule

// ----- hdl/lpm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LPM route table checker
// Port-level checks on the route table, bound to the top level.
// ----------------------------------------------------------------------------
module lpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [79:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   a_ready_follows_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("Request ready does not follow the response stall.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled response changed.");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[40:1] == 40'd0)
      else $error("Miss carries a non-zero hop or port.");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[41]) && rsp_tdata[47:42] == 6'd0)
      else $error("Response flags are inconsistent.");

endmodule

bind lpm_route_table_top lpm_checker u_lpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
